[src/tcw_pkg.sv]
// Shared types and constants for the text console writer.
package tcw_pkg;

  // Character codes the console reacts to.
  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_ESCAPE   = 8'd27;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SGR_END  = 8'h6D;

  // Display command codes.
  localparam logic CMD_PUT    = 1'b0;
  localparam logic CMD_SCROLL = 1'b1;

  // Line width after reset.
  localparam logic [7:0] LINE_WIDTH_RESET = 8'd80;

  // Width of line width and column arithmetic, wide enough for 256.
  localparam int unsigned WIDTH_BITS = 9;

  // Input beat.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_text;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic       command;
    logic [6:0] column;
    logic [7:0] character;
    logic       last_of_run;
  } out_beat_t;

  // Job handed from the classifier to the sequencer. Steps run in the order
  // store, flush, plain.
  typedef struct packed {
    logic       store;
    logic       flush;
    logic       plain;
    logic [7:0] byte_value;
  } job_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FLUSH,
    S_FLUSH_WRAP,
    S_DEFER,
    S_CHAR,
    S_WRAP
  } back_state_e;

endpackage

[src/text_console_writer.sv]
// Top level: a bottom-line scrolling console writer with color sequence removal.
// Each accepted byte becomes a job, except the end of a color sequence, which is swallowed.
// The sequencer stores a held byte; a printed byte, newline or escape may first need a
// deferred scroll, and a put can be followed by a wrap scroll, as can each put of a flush.
// The sequencer waits while the output register is full. A two-entry job queue
// lets input beats be taken while commands are still going out.
// Reset: line width returns to 80, the first byte is preceded by a scroll; no clearing pass.
module text_console_writer #(
  parameter int unsigned MAX_COLUMNS  = 128,
  parameter int unsigned ESC_HOLD_MAX = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  tcw_pkg::in_beat_t  in_beat_i,
  output logic               empty,
  input  logic               pop,
  output tcw_pkg::out_beat_t out_beat_o
);
  import tcw_pkg::*;

  logic accept;
  logic job_valid;
  job_t job_in;
  job_t job_out;
  logic job_empty;
  logic job_pop;

  assign accept = push && !full;

  // Classifier.
  tcw_front #(
    .ESC_HOLD_MAX(ESC_HOLD_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_beat_i  (in_beat_i),
    .job_valid_o(job_valid),
    .job_o      (job_in)
  );

  // Job queue.
  tcw_fifo #(
    .DEPTH(2)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept && job_valid),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (job_pop),
    .empty_o(job_empty),
    .data_o (job_out)
  );

  // Sequencer and output register.
  tcw_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .ESC_HOLD_MAX(ESC_HOLD_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .job_empty_i(job_empty),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_beat_o (out_beat_o)
  );

endmodule

[src/tcw_front.sv]
// Classifier: tracks escape sequences and turns each accepted byte, but the end of a color sequence, into a job.
module tcw_front #(
  parameter int unsigned ESC_HOLD_MAX = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  tcw_pkg::in_beat_t in_beat_i,
  output logic              job_valid_o,
  output tcw_pkg::job_t     job_o
);
  import tcw_pkg::*;

  localparam int unsigned CntW = $clog2(ESC_HOLD_MAX + 1);

  logic            esc_q, esc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      ch;
  logic            eot;
  logic            holdable;

  assign ch  = in_beat_i.byte_value;
  assign eot = in_beat_i.end_of_text;
  assign holdable = (ch == CH_SEMI) || (ch == CH_LBRACKET) ||
                    ((ch >= CH_ZERO) && (ch <= CH_NINE));

  // Classify the byte against the escape tracking state.
  always_comb begin
    job_valid_o      = 1'b1;
    job_o            = '0;
    job_o.byte_value = ch;
    esc_d            = esc_q;
    cnt_d            = cnt_q;
    priority if (esc_q && (ch == CH_SGR_END)) begin
      // A complete color sequence is swallowed.
      job_valid_o = 1'b0;
      esc_d       = 1'b0;
      cnt_d       = '0;
    end else if (esc_q && holdable && (cnt_q < CntW'(ESC_HOLD_MAX))) begin
      job_o.store = 1'b1;
      job_o.flush = eot;
      esc_d       = !eot;
      cnt_d       = eot ? '0 : cnt_q + CntW'(1);
    end else if (esc_q) begin
      // Sequence broken or too long: print what was held, then this byte.
      job_o.flush = 1'b1;
      job_o.plain = 1'b1;
      esc_d       = (ch == CH_ESCAPE) && !eot;
      cnt_d       = '0;
    end else begin
      job_o.plain = 1'b1;
      esc_d       = (ch == CH_ESCAPE) && !eot;
      cnt_d       = '0;
    end
  end

  // Escape tracking registers advance on each accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
      cnt_q <= '0;
    end else if (accept_i) begin
      esc_q <= esc_d;
      cnt_q <= cnt_d;
    end
  end

  // Outside an escape nothing may be counted as held.
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !esc_q |-> (cnt_q == '0))
    else $error("held count nonzero outside an escape");

endmodule

[src/tcw_fifo.sv]
// Short job queue between the classifier and the sequencer.
module tcw_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcw_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tcw_pkg::job_t data_o
);
  import tcw_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // The classifier must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into a full queue");

endmodule

[src/tcw_back.sv]
// Sequencer: carries out jobs and emits one display command per beat.
module tcw_back #(
  parameter int unsigned MAX_COLUMNS  = 128,
  parameter int unsigned ESC_HOLD_MAX = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               job_empty_i,
  input  tcw_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output tcw_pkg::out_beat_t out_beat_o
);
  import tcw_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_COLUMNS);
  localparam int unsigned CntW = $clog2(ESC_HOLD_MAX + 1);
  localparam int unsigned IdxW = (ESC_HOLD_MAX > 1) ? $clog2(ESC_HOLD_MAX) : 1;
  localparam int unsigned WW   = WIDTH_BITS;

  back_state_e     state_q, state_d;
  job_t            job_q, job_d;
  logic [ColW-1:0] cursor_q, cursor_d;
  logic            defer_q, defer_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [7:0]      held_q [ESC_HOLD_MAX];
  logic [7:0]      lw_q;
  out_beat_t       out_q;
  logic            out_v_q;

  logic            hold_we;
  logic            emit;
  out_beat_t       emit_beat;
  logic            emit_ok;
  logic [WW-1:0]   eff_w;
  logic [WW-1:0]   nxt_col;
  logic            wrap;
  logic            printable;
  logic            plain_out;
  logic [CntW-1:0] idx_next;
  logic            more_flush;
  logic [7:0]      held_rd;
  logic [ColW+6:0] col_ext;
  logic [6:0]      col;

  // Effective width: zero counts as one, large values saturate.
  always_comb begin
    if (lw_q == '0) begin
      eff_w = WW'(1);
    end else if (WW'(lw_q) > WW'(MAX_COLUMNS)) begin
      eff_w = WW'(MAX_COLUMNS);
    end else begin
      eff_w = WW'(lw_q);
    end
  end

  assign nxt_col    = WW'(cursor_q) + WW'(1);
  assign wrap       = (nxt_col >= eff_w);
  assign printable  = (job_q.byte_value != CH_NEWLINE) &&
                      (job_q.byte_value != CH_ESCAPE);
  assign plain_out  = job_q.plain && (defer_q || printable);
  assign idx_next   = idx_q + CntW'(1);
  assign more_flush = (idx_next < cnt_q);
  assign held_rd    = held_q[idx_q[IdxW-1:0]];
  assign col_ext    = {7'b0, cursor_q};
  assign col        = col_ext[6:0];
  assign emit_ok    = !out_v_q || pop_i;

  // Next state and command generation.
  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    cursor_d  = cursor_q;
    defer_d   = defer_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    job_pop_o = 1'b0;
    hold_we   = 1'b0;
    emit      = 1'b0;
    emit_beat = '0;
    unique case (state_q)
      S_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          idx_d     = '0;
          if (job_i.store) begin
            hold_we = 1'b1;
            cnt_d   = cnt_q + CntW'(1);
          end
          state_d = job_i.flush ? S_FLUSH : S_DEFER;
        end
      end
      S_FLUSH: begin
        if (idx_q < cnt_q) begin
          if (emit_ok) begin
            emit                  = 1'b1;
            emit_beat.command     = CMD_PUT;
            emit_beat.column      = col;
            emit_beat.character   = held_rd;
            emit_beat.last_of_run = !wrap && !more_flush && !plain_out;
            if (wrap) begin
              cursor_d = '0;
              state_d  = S_FLUSH_WRAP;
            end else begin
              cursor_d = ColW'(nxt_col);
              idx_d    = idx_next;
            end
          end
        end else begin
          cnt_d   = '0;
          state_d = S_DEFER;
        end
      end
      S_FLUSH_WRAP: begin
        if (emit_ok) begin
          emit                  = 1'b1;
          emit_beat.command     = CMD_SCROLL;
          emit_beat.last_of_run = !more_flush && !plain_out;
          idx_d                 = idx_next;
          state_d               = S_FLUSH;
        end
      end
      S_DEFER: begin
        if (!job_q.plain) begin
          state_d = S_IDLE;
        end else if (defer_q) begin
          // Scroll left over from an earlier newline or from reset.
          if (emit_ok) begin
            emit                  = 1'b1;
            emit_beat.command     = CMD_SCROLL;
            emit_beat.last_of_run = !printable;
            defer_d               = 1'b0;
            cursor_d              = '0;
            state_d               = S_CHAR;
          end
        end else begin
          state_d = S_CHAR;
        end
      end
      S_CHAR: begin
        if (job_q.byte_value == CH_NEWLINE) begin
          defer_d = 1'b1;
          state_d = S_IDLE;
        end else if (job_q.byte_value == CH_ESCAPE) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else if (emit_ok) begin
          emit                  = 1'b1;
          emit_beat.command     = CMD_PUT;
          emit_beat.column      = col;
          emit_beat.character   = job_q.byte_value;
          emit_beat.last_of_run = !wrap;
          if (wrap) begin
            cursor_d = '0;
            state_d  = S_WRAP;
          end else begin
            cursor_d = ColW'(nxt_col);
            state_d  = S_IDLE;
          end
        end
      end
      S_WRAP: begin
        if (emit_ok) begin
          emit                  = 1'b1;
          emit_beat.command     = CMD_SCROLL;
          emit_beat.last_of_run = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer state and cursor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cursor_q <= '0;
      defer_q  <= 1'b1;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      defer_q  <= defer_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
    end
  end

  // Line width register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= LINE_WIDTH_RESET;
    end else if (cfg_we_i) begin
      lw_q <= cfg_wdata_i;
    end
  end

  // Current job and held escape bytes.
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (hold_we) begin
      held_q[cnt_q[IdxW-1:0]] <= job_i.byte_value;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (emit) begin
      out_v_q <= 1'b1;
    end else if (pop_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= emit_beat;
    end
  end

  assign empty_o    = !out_v_q;
  assign out_beat_o = out_q;

  // The flush index never runs past the held count.
  a_flush_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FLUSH) || (state_q == S_FLUSH_WRAP)) |-> (idx_q <= cnt_q))
    else $error("flush index beyond held count");

  // A wrap scroll only follows a character put.
  a_wrap_after_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRAP) |-> (($past(state_q) == S_CHAR) || ($past(state_q) == S_WRAP)))
    else $error("wrap scroll without a preceding put");

  // A new beat is only loaded when the output register is free or drained.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_v_q) |-> pop_i)
    else $error("result overwritten before it was taken");

endmodule
